// File: hdl/dir_pkg.sv
package dir_pkg;

    localparam int TAG_BITS_DEF = 16;

    // bus actions
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_DONE   = 3'd2;
    localparam logic [2:0] ACT_DISC   = 3'd3;
    localparam logic [2:0] ACT_RESET  = 3'd4;

    // register offsets
    localparam logic [7:0] OFF_STATUS  = 8'h00;
    localparam logic [7:0] OFF_COVER   = 8'h04;
    localparam logic [7:0] OFF_CMD0    = 8'h08;
    localparam logic [7:0] OFF_CMD1    = 8'h0C;
    localparam logic [7:0] OFF_CMD2    = 8'h10;
    localparam logic [7:0] OFF_DMAADR  = 8'h14;
    localparam logic [7:0] OFF_DMALEN  = 8'h18;
    localparam logic [7:0] OFF_CONTROL = 8'h1C;
    localparam logic [7:0] OFF_IMM     = 8'h20;
    localparam logic [7:0] OFF_CONFIG  = 8'h24;

    // command opcodes
    localparam logic [7:0] OP_READ_DISC  = 8'hA8;
    localparam logic [7:0] OP_AUDIO_ST   = 8'hAB;
    localparam logic [7:0] OP_REQ_ERR    = 8'hE0;
    localparam logic [7:0] OP_STREAM     = 8'hE1;
    localparam logic [7:0] OP_STREAM_ST  = 8'hE2;
    localparam logic [7:0] OP_STOP_MOTOR = 8'hE3;
    localparam logic [7:0] OP_AUDIO_CFG  = 8'hE4;

    localparam logic [31:0] ERR_INVALID  = 32'h0005_2000;
    localparam logic [31:0] ERR_NOMEDIUM = 32'h0002_3A00;
    localparam logic [31:0] ADDR_MASK    = 32'h03FF_FFE0;
    localparam logic [31:0] LEN_MASK     = 32'hFFFF_FFE0;
    localparam logic [33:0] POS_MASK     = ~34'h7FFF;

endpackage

// File: hdl/disc_interface_registers_top.sv
// Register block of a disc-drive interface. Each input beat (bus read or write,
// media completion, disc presence change or drive reset) is decoded combinationally,
// applied to the register state when taken and gives exactly one result beat; a new
// beat can be taken every cycle, limited only by the single output register.
// Writing control with TSTART runs the command: drive-local commands finish at
// once, others are handed to the backend (media_request) if one is attached (else
// they fail at once) and finish when a completion beat with the matching tag
// arrives. Status and cover interrupt bits are write-one-to-clear.
module disc_interface_registers_top #(
    parameter int TAG_BITS = dir_pkg::TAG_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  offset,
    input  logic [31:0] write_data,
    input  logic [15:0] complete_tag,
    input  logic        complete_ok,
    input  logic [31:0] complete_immediate,
    input  logic [31:0] complete_bytes,
    input  logic [31:0] complete_error,
    input  logic        disc_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ack,
    output logic [31:0] read_data,
    output logic        irq_pending,
    output logic        media_request,
    output logic [31:0] req_cmd_word0,
    output logic [31:0] req_cmd_word1,
    output logic [31:0] req_cmd_word2,
    output logic [31:0] req_dma_address,
    output logic [31:0] req_dma_length,
    output logic [2:0]  req_control,
    output logic [31:0] req_immediate,
    output logic [15:0] req_tag
);

    logic             backend_reg;
    logic [6:0]       status_reg, status_next;
    logic [2:0]       cover_reg, cover_next;
    logic [31:0]      cmd0_reg, cmd0_next, cmd1_reg, cmd1_next, cmd2_reg, cmd2_next;
    logic [31:0]      dma_addr_reg, dma_addr_next, dma_len_reg, dma_len_next;
    logic [2:0]       control_reg, control_next;
    logic [31:0]      imm_reg, imm_next, err_reg, err_next;
    logic [31:0]      config_reg, config_next;
    logic             disc_reg, disc_next;
    logic             aon_reg, aon_next, arun_reg, arun_next, astop_reg, astop_next;
    logic [3:0]       abuf_reg, abuf_next;
    logic [33:0]      acs_reg, acs_next, apos_reg, apos_next, ans_reg, ans_next;
    logic [31:0]      acl_reg, acl_next, anl_reg, anl_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    logic        ack_c, req_c, irq_c;
    logic [31:0] rdata_c;
    logic        take;

    assign in_ready  = !out_valid || out_ready;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // decode and state update for one beat
    always_comb
    begin
        logic [31:0] c0;
        logic [7:0]  op, sub;
        logic        fin, fok, eject, kill;
        logic [31:0] fimm, fbytes, ferr, t, r;
        logic [33:0] start;

        status_next = status_reg;   cover_next = cover_reg;
        cmd0_next = cmd0_reg;       cmd1_next = cmd1_reg;   cmd2_next = cmd2_reg;
        dma_addr_next = dma_addr_reg; dma_len_next = dma_len_reg;
        control_next = control_reg; imm_next = imm_reg;     err_next = err_reg;
        config_next = config_reg;   disc_next = disc_reg;
        aon_next = aon_reg;         arun_next = arun_reg;   astop_next = astop_reg;
        abuf_next = abuf_reg;       acs_next = acs_reg;     apos_next = apos_reg;
        ans_next = ans_reg;         acl_next = acl_reg;     anl_next = anl_reg;
        tag_next = tag_reg;
        ack_c = 1'b0; req_c = 1'b0; rdata_c = '0;
        fin = 1'b0; fok = 1'b0; fimm = '0; fbytes = '0; ferr = '0;
        c0 = cmd0_reg; op = c0[31:24]; sub = c0[23:16];
        eject = c0[17]; kill = c0[20]; t = '0; r = '0;
        start = {cmd1_reg, 2'b00};

        unique case (action)
            dir_pkg::ACT_READ:
            begin
                ack_c = 1'b1;
                unique case (offset)
                    dir_pkg::OFF_STATUS:  rdata_c = {25'd0, status_reg};
                    dir_pkg::OFF_COVER:   rdata_c = {29'd0, cover_reg};
                    dir_pkg::OFF_CMD0:    rdata_c = cmd0_reg;
                    dir_pkg::OFF_CMD1:    rdata_c = cmd1_reg;
                    dir_pkg::OFF_CMD2:    rdata_c = cmd2_reg;
                    dir_pkg::OFF_DMAADR:  rdata_c = dma_addr_reg;
                    dir_pkg::OFF_DMALEN:  rdata_c = dma_len_reg;
                    dir_pkg::OFF_CONTROL: rdata_c = {29'd0, control_reg};
                    dir_pkg::OFF_IMM:     rdata_c = imm_reg;
                    dir_pkg::OFF_CONFIG:  rdata_c = config_reg;
                    default:              ack_c = 1'b0;
                endcase
            end
            dir_pkg::ACT_WRITE:
            begin
                ack_c = 1'b1;
                unique case (offset)
                    dir_pkg::OFF_STATUS:
                    begin
                        status_next = (status_reg & 7'h54) | (write_data[6:0] & 7'h2B);
                        if (write_data[2]) status_next[2] = 1'b0;
                        if (write_data[4]) status_next[4] = 1'b0;
                        if (write_data[6]) status_next[6] = 1'b0;
                        if (write_data[0])
                        begin
                            control_next[0] = 1'b0;
                            status_next[6] = 1'b1;
                        end
                    end
                    dir_pkg::OFF_COVER:
                        cover_next = {cover_reg[2] & ~write_data[2], write_data[1], ~disc_reg};
                    dir_pkg::OFF_CMD0:   cmd0_next = write_data;
                    dir_pkg::OFF_CMD1:   cmd1_next = write_data;
                    dir_pkg::OFF_CMD2:   cmd2_next = write_data;
                    dir_pkg::OFF_DMAADR: dma_addr_next = write_data & dir_pkg::ADDR_MASK;
                    dir_pkg::OFF_DMALEN: dma_len_next = write_data & dir_pkg::LEN_MASK;
                    dir_pkg::OFF_IMM:    imm_next = write_data;
                    dir_pkg::OFF_CONTROL:
                    begin
                        control_next = write_data[2:0];
                        if (write_data[0])
                        begin
                            tag_next = tag_reg + 1'b1;
                            fin = 1'b1; fok = 1'b1; fimm = imm_reg;
                            // command dispatch
                            if (!disc_reg && (op == dir_pkg::OP_READ_DISC ||
                                              op == dir_pkg::OP_AUDIO_ST))
                            begin
                                fok = 1'b0; ferr = dir_pkg::ERR_NOMEDIUM;
                            end
                            else if (op == dir_pkg::OP_REQ_ERR)
                            begin
                                fimm = err_reg; err_next = '0;
                            end
                            else if (op == dir_pkg::OP_AUDIO_ST)
                                fimm = imm_reg;
                            else if (op == dir_pkg::OP_AUDIO_CFG)
                            begin
                                aon_next = c0[16]; abuf_next = c0[3:0]; fimm = '0;
                                if (!c0[16])
                                begin
                                    arun_next = 1'b0; astop_next = 1'b0;
                                end
                            end
                            else if (op == dir_pkg::OP_STREAM)
                            begin
                                if (!aon_reg || !disc_reg || sub > 8'd1)
                                begin
                                    fok = 1'b0; ferr = dir_pkg::ERR_INVALID;
                                end
                                else
                                begin
                                    fimm = '0;
                                    if (sub == 8'd0)
                                    begin
                                        if (cmd1_reg == '0 && cmd2_reg == '0)
                                            astop_next = 1'b1;
                                        else if (!astop_reg)
                                        begin
                                            ans_next = start; anl_next = cmd2_reg;
                                            if (!arun_reg)
                                            begin
                                                acs_next = start; acl_next = cmd2_reg;
                                                apos_next = start; arun_next = 1'b1;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        astop_next = 1'b0; arun_next = 1'b0;
                                    end
                                end
                            end
                            else if (op == dir_pkg::OP_STREAM_ST)
                            begin
                                if (!aon_reg || !disc_reg || sub > 8'd3)
                                begin
                                    fok = 1'b0; ferr = dir_pkg::ERR_INVALID;
                                end
                                else
                                begin
                                    unique case (sub[1:0])
                                        2'd0: r = {31'd0, arun_reg};
                                        2'd1: r = 32'((apos_reg & dir_pkg::POS_MASK) >> 2);
                                        2'd2: r = acs_reg[33:2];
                                        default: r = acl_reg;
                                    endcase
                                    fimm = r;
                                end
                            end
                            else if (op == dir_pkg::OP_STOP_MOTOR)
                            begin
                                if (eject && !kill && disc_reg)
                                begin
                                    disc_next = 1'b0;
                                    cover_next = {1'b1, cover_reg[1], 1'b1};
                                end
                            end
                            else if (backend_reg)
                            begin
                                fin = 1'b0; req_c = 1'b1;
                            end
                            else
                            begin
                                fok = 1'b0;
                                ferr = disc_reg ? dir_pkg::ERR_INVALID : dir_pkg::ERR_NOMEDIUM;
                            end
                        end
                    end
                    default: ack_c = 1'b0;
                endcase
            end
            dir_pkg::ACT_DONE:
            begin
                if (control_reg[0] && (64'(complete_tag) == 64'(tag_reg)))
                begin
                    ack_c = 1'b1; fin = 1'b1; fok = complete_ok;
                    fimm = complete_immediate; fbytes = complete_bytes;
                    ferr = complete_error;
                end
            end
            dir_pkg::ACT_DISC:
            begin
                ack_c = 1'b1;
                if (disc_reg != disc_flag)
                begin
                    disc_next = disc_flag;
                    cover_next = {1'b1, cover_reg[1], ~disc_flag};
                end
            end
            dir_pkg::ACT_RESET:
            begin
                ack_c = 1'b1;
                tag_next = tag_reg + 1'b1;
                status_next = '0; disc_next = disc_flag; cover_next = {2'b00, ~disc_flag};
                cmd0_next = '0; cmd1_next = '0; cmd2_next = '0;
                dma_addr_next = '0; dma_len_next = '0; control_next = '0; imm_next = '0;
                config_next = 32'd1; err_next = '0;
                aon_next = 1'b0; arun_next = 1'b0; astop_next = 1'b0; abuf_next = '0;
                acs_next = '0; apos_next = '0; ans_next = '0; acl_next = '0; anl_next = '0;
            end
            default: ;
        endcase

        // command completion
        if (fin)
        begin
            imm_next = fimm;
            control_next[0] = 1'b0;
            if (fok)
            begin
                if (control_next[1])
                begin
                    t = (fbytes < dma_len_next) ? fbytes : dma_len_next;
                    dma_addr_next = (dma_addr_next + t) & dir_pkg::ADDR_MASK;
                    dma_len_next = dma_len_next - t;
                end
                status_next[4] = 1'b1;
            end
            else
            begin
                err_next = ferr;
                status_next[2] = 1'b1;
            end
        end

        irq_c = (status_next[2] & status_next[1]) | (status_next[4] & status_next[3]) |
                (status_next[6] & status_next[5]) | (cover_next[2] & cover_next[1]);
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backend_reg <= 1'b1;
            status_reg <= '0; cover_reg <= '0; cmd0_reg <= '0; cmd1_reg <= '0;
            cmd2_reg <= '0; dma_addr_reg <= '0; dma_len_reg <= '0; control_reg <= '0;
            imm_reg <= '0; err_reg <= '0; config_reg <= 32'd1; disc_reg <= 1'b1;
            aon_reg <= 1'b0; arun_reg <= 1'b0; astop_reg <= 1'b0; abuf_reg <= '0;
            acs_reg <= '0; apos_reg <= '0; ans_reg <= '0; acl_reg <= '0; anl_reg <= '0;
            tag_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid) backend_reg <= cfg_data;
            if (out_valid && out_ready) out_valid <= 1'b0;
            if (take)
            begin
                status_reg <= status_next; cover_reg <= cover_next;
                cmd0_reg <= cmd0_next; cmd1_reg <= cmd1_next; cmd2_reg <= cmd2_next;
                dma_addr_reg <= dma_addr_next; dma_len_reg <= dma_len_next;
                control_reg <= control_next; imm_reg <= imm_next; err_reg <= err_next;
                config_reg <= config_next; disc_reg <= disc_next;
                aon_reg <= aon_next; arun_reg <= arun_next; astop_reg <= astop_next;
                abuf_reg <= abuf_next; acs_reg <= acs_next; apos_reg <= apos_next;
                ans_reg <= ans_next; acl_reg <= acl_next; anl_reg <= anl_next;
                tag_reg <= tag_next;
                out_valid <= 1'b1;
                ack <= ack_c; read_data <= rdata_c; irq_pending <= irq_c;
                media_request <= req_c;
                req_cmd_word0 <= req_c ? cmd0_next : '0;
                req_cmd_word1 <= req_c ? cmd1_next : '0;
                req_cmd_word2 <= req_c ? cmd2_next : '0;
                req_dma_address <= req_c ? dma_addr_next : '0;
                req_dma_length <= req_c ? dma_len_next : '0;
                req_control <= req_c ? control_next : '0;
                req_immediate <= req_c ? imm_next : '0;
                req_tag <= req_c ? 16'(tag_next) : '0;
            end
        end
    end

    // a hand-off always carries a running command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && media_request |-> req_control[0]) else $error("req without start");
    // a request is never an error beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && media_request |-> ack) else $error("req without ack");
    // read data is zero unless something was acknowledged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ack |-> read_data == '0 && !media_request) else $error("nack data");
    // cover open bit follows disc presence
    assert property (@(posedge clk) disable iff (!rst_n)
        cover_reg[0] == !disc_reg) else $error("cover mismatch");

endmodule

// File: tb/tb_disc_interface_registers_top.sv
`timescale 1ns / 100ps

module tb_disc_interface_registers_top;

    // status, cover and control bit positions
    localparam logic [6:0] ST_BRK     = 7'h01;
    localparam logic [6:0] ST_ERRMASK = 7'h02;
    localparam logic [6:0] ST_ERRINT  = 7'h04;
    localparam logic [6:0] ST_TCMASK  = 7'h08;
    localparam logic [6:0] ST_TCINT   = 7'h10;
    localparam logic [6:0] ST_BRKMASK = 7'h20;
    localparam logic [6:0] ST_BRKINT  = 7'h40;
    localparam logic [2:0] CV_OPEN    = 3'h1;
    localparam logic [2:0] CV_MASK    = 3'h2;
    localparam logic [2:0] CV_INT     = 3'h4;
    localparam logic [2:0] CT_START   = 3'h1;
    localparam logic [2:0] CT_DMA     = 3'h2;
    localparam logic [2:0] CT_WRITE   = 3'h4;
    localparam int         LONG_HOLD  = 200;
    localparam int         HOLD_BEAT  = 150;

    typedef struct packed {
        logic [2:0]  act;
        logic [7:0]  off;
        logic [31:0] wdata;
        logic [15:0] ctag;
        logic        cok;
        logic [31:0] cimm;
        logic [31:0] cbytes;
        logic [31:0] cerr;
        logic        disc;
        logic        live_tag;
    } bus_item_t;

    typedef struct packed {
        logic        ack;
        logic [31:0] rdata;
        logic        irq;
        logic        mreq;
        logic [31:0] w0, w1, w2;
        logic [31:0] dadr, dlen;
        logic [2:0]  ctl;
        logic [31:0] imm;
        logic [15:0] tag;
    } reg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic cfg_ready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    bus_item_t cur = '0;
    reg_result_t got;

    bus_item_t   pending_q[$];
    reg_result_t expected_q[$];
    int  errs = 0;
    bit  quiet = 1'b0;
    int  gap_cnt = 0;
    int  stall_cnt = 0;
    int  hold_cnt = 0;
    bit  held = 1'b0;
    int  beats = 0;

    // drive-side register image
    logic        attached;
    logic [6:0]  st;
    logic [2:0]  cv, ctl;
    logic [31:0] cw0, cw1, cw2, dadr, dlen, imm, cfgw, lerr;
    logic        disc_in, aon, arun, astop;
    logic [3:0]  abuf;
    logic [33:0] acs, apos, ans;
    logic [31:0] acl, anl;
    logic [15:0] tag_c;
    logic        req;

    disc_interface_registers_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(cur.act), .offset(cur.off), .write_data(cur.wdata),
        .complete_tag(cur.ctag), .complete_ok(cur.cok),
        .complete_immediate(cur.cimm), .complete_bytes(cur.cbytes),
        .complete_error(cur.cerr), .disc_flag(cur.disc),
        .out_valid(out_valid), .out_ready(out_ready),
        .ack(got.ack), .read_data(got.rdata), .irq_pending(got.irq),
        .media_request(got.mreq), .req_cmd_word0(got.w0), .req_cmd_word1(got.w1),
        .req_cmd_word2(got.w2), .req_dma_address(got.dadr),
        .req_dma_length(got.dlen), .req_control(got.ctl),
        .req_immediate(got.imm), .req_tag(got.tag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- register image update ----------------
    function automatic void drive_reset(logic disc);
        tag_c = tag_c + 16'd1;
        st = '0;
        disc_in = disc;
        cv = disc ? 3'h0 : CV_OPEN;
        cw0 = '0; cw1 = '0; cw2 = '0;
        dadr = '0; dlen = '0; ctl = '0; imm = '0;
        cfgw = 32'd1;
        lerr = '0;
        aon = 1'b0; arun = 1'b0; astop = 1'b0;
        abuf = '0;
        acs = '0; apos = '0; ans = '0;
        acl = '0; anl = '0;
    endfunction

    function automatic void set_presence(logic present);
        if (disc_in != present)
        begin
            disc_in = present;
            if (present) cv = cv & ~CV_OPEN;
            else cv = cv | CV_OPEN;
            cv = cv | CV_INT;
        end
    endfunction

    function automatic void finish_cmd(logic ok, logic [31:0] v, logic [31:0] bytes,
                                       logic [31:0] err);
        logic [31:0] t;
        imm = v;
        ctl = ctl & ~CT_START;
        if (ok)
        begin
            if (ctl & CT_DMA)
            begin
                t = (bytes < dlen) ? bytes : dlen;
                dadr = (dadr + t) & dir_pkg::ADDR_MASK;
                dlen = dlen - t;
            end
            st = st | ST_TCINT;
        end
        else
        begin
            lerr = err;
            st = st | ST_ERRINT;
        end
    endfunction

    function automatic void run_cmd();
        logic [7:0]  op;
        logic [7:0]  sub;
        logic [31:0] e;
        logic [31:0] r;
        logic [33:0] start;
        op = cw0[31:24];
        sub = cw0[23:16];
        if (!disc_in && (op == dir_pkg::OP_READ_DISC || op == dir_pkg::OP_AUDIO_ST))
            finish_cmd(1'b0, imm, '0, dir_pkg::ERR_NOMEDIUM);
        else if (op == dir_pkg::OP_REQ_ERR)
        begin
            e = lerr;
            lerr = '0;
            finish_cmd(1'b1, e, '0, '0);
        end
        else if (op == dir_pkg::OP_AUDIO_ST)
            finish_cmd(1'b1, imm, '0, '0);
        else if (op == dir_pkg::OP_AUDIO_CFG)
        begin
            aon = cw0[16];
            abuf = cw0[3:0];
            if (!aon)
            begin
                arun = 1'b0;
                astop = 1'b0;
            end
            finish_cmd(1'b1, '0, '0, '0);
        end
        else if (op == dir_pkg::OP_STREAM)
        begin
            if (!aon || !disc_in || sub > 8'd1)
                finish_cmd(1'b0, imm, '0, dir_pkg::ERR_INVALID);
            else
            begin
                if (sub == 8'd0)
                begin
                    start = {cw1, 2'b00};
                    if (start == '0 && cw2 == '0)
                        astop = 1'b1;
                    else if (!astop)
                    begin
                        ans = start;
                        anl = cw2;
                        if (!arun)
                        begin
                            acs = start;
                            acl = cw2;
                            apos = start;
                            arun = 1'b1;
                        end
                    end
                end
                else
                begin
                    astop = 1'b0;
                    arun = 1'b0;
                end
                finish_cmd(1'b1, '0, '0, '0);
            end
        end
        else if (op == dir_pkg::OP_STREAM_ST)
        begin
            if (!aon || !disc_in || sub > 8'd3)
                finish_cmd(1'b0, imm, '0, dir_pkg::ERR_INVALID);
            else
            begin
                case (sub)
                    8'd0:    r = {31'd0, arun};
                    8'd1:    r = 32'((apos & dir_pkg::POS_MASK) >> 2);
                    8'd2:    r = 32'(acs >> 2);
                    default: r = acl;
                endcase
                finish_cmd(1'b1, r, '0, '0);
            end
        end
        else if (op == dir_pkg::OP_STOP_MOTOR)
        begin
            if (cw0[17] && !cw0[20]) set_presence(1'b0);
            finish_cmd(1'b1, imm, '0, '0);
        end
        else if (attached)
            req = 1'b1;
        else
            finish_cmd(1'b0, imm, '0,
                       disc_in ? dir_pkg::ERR_INVALID : dir_pkg::ERR_NOMEDIUM);
    endfunction

    function automatic logic reg_write(logic [7:0] off, logic [31:0] v);
        logic [6:0] wr;
        wr = ST_BRK | ST_ERRMASK | ST_TCMASK | ST_BRKMASK;
        reg_write = 1'b1;
        case (off)
            dir_pkg::OFF_STATUS:
            begin
                st = (st & ~wr) | (v[6:0] & wr);
                if (v[6:0] & ST_ERRINT) st = st & ~ST_ERRINT;
                if (v[6:0] & ST_TCINT) st = st & ~ST_TCINT;
                if (v[6:0] & ST_BRKINT) st = st & ~ST_BRKINT;
                if (v[6:0] & ST_BRK)
                begin
                    ctl = ctl & ~CT_START;
                    st = st | ST_BRKINT;
                end
            end
            dir_pkg::OFF_COVER:
            begin
                cv = (v[2:0] & CV_MASK) | (disc_in ? 3'h0 : CV_OPEN) | (cv & CV_INT);
                if (v[2:0] & CV_INT) cv = cv & ~CV_INT;
            end
            dir_pkg::OFF_CMD0:    cw0 = v;
            dir_pkg::OFF_CMD1:    cw1 = v;
            dir_pkg::OFF_CMD2:    cw2 = v;
            dir_pkg::OFF_DMAADR:  dadr = v & dir_pkg::ADDR_MASK;
            dir_pkg::OFF_DMALEN:  dlen = v & dir_pkg::LEN_MASK;
            dir_pkg::OFF_CONTROL:
            begin
                ctl = v[2:0];
                if (ctl & CT_START)
                begin
                    tag_c = tag_c + 16'd1;
                    run_cmd();
                end
            end
            dir_pkg::OFF_IMM:     imm = v;
            default:              reg_write = 1'b0;
        endcase
    endfunction

    function automatic reg_result_t predict_beat(bus_item_t it);
        reg_result_t r;
        r = '0;
        req = 1'b0;
        case (it.act)
            dir_pkg::ACT_READ:
            begin
                r.ack = 1'b1;
                case (it.off)
                    dir_pkg::OFF_STATUS:  r.rdata = {25'd0, st};
                    dir_pkg::OFF_COVER:   r.rdata = {29'd0, cv};
                    dir_pkg::OFF_CMD0:    r.rdata = cw0;
                    dir_pkg::OFF_CMD1:    r.rdata = cw1;
                    dir_pkg::OFF_CMD2:    r.rdata = cw2;
                    dir_pkg::OFF_DMAADR:  r.rdata = dadr;
                    dir_pkg::OFF_DMALEN:  r.rdata = dlen;
                    dir_pkg::OFF_CONTROL: r.rdata = {29'd0, ctl};
                    dir_pkg::OFF_IMM:     r.rdata = imm;
                    dir_pkg::OFF_CONFIG:  r.rdata = cfgw;
                    default:              r.ack = 1'b0;
                endcase
            end
            dir_pkg::ACT_WRITE: r.ack = reg_write(it.off, it.wdata);
            dir_pkg::ACT_DONE:
            begin
                if (it.ctag == tag_c && (ctl & CT_START))
                begin
                    finish_cmd(it.cok, it.cimm, it.cbytes, it.cerr);
                    r.ack = 1'b1;
                end
            end
            dir_pkg::ACT_DISC:
            begin
                set_presence(it.disc);
                r.ack = 1'b1;
            end
            dir_pkg::ACT_RESET:
            begin
                drive_reset(it.disc);
                r.ack = 1'b1;
            end
            default: ;
        endcase
        r.irq = ((st & ST_ERRINT) != 0 && (st & ST_ERRMASK) != 0) ||
                ((st & ST_TCINT) != 0 && (st & ST_TCMASK) != 0) ||
                ((st & ST_BRKINT) != 0 && (st & ST_BRKMASK) != 0) ||
                ((cv & CV_INT) != 0 && (cv & CV_MASK) != 0);
        if (req)
        begin
            r.mreq = 1'b1;
            r.w0 = cw0; r.w1 = cw1; r.w2 = cw2;
            r.dadr = dadr; r.dlen = dlen;
            r.ctl = ctl; r.imm = imm; r.tag = tag_c;
        end
        return r;
    endfunction

    // ---------------- stimulus building ----------------
    function automatic bus_item_t mk(logic [2:0] a, logic [7:0] o, logic [31:0] d);
        bus_item_t it;
        it.act = a;
        it.off = o;
        it.wdata = d;
        it.ctag = 16'($urandom);
        it.cok = 1'($urandom);
        it.cimm = $urandom;
        it.cbytes = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096);
        it.cerr = $urandom;
        it.disc = 1'($urandom);
        it.live_tag = 1'b0;
        return it;
    endfunction

    task automatic push(logic [2:0] a, logic [7:0] o, logic [31:0] d);
        pending_q.push_back(mk(a, o, d));
    endtask

    task automatic push_done(logic ok);
        bus_item_t it;
        it = mk(dir_pkg::ACT_DONE, 8'($urandom), $urandom);
        it.cok = ok;
        it.live_tag = 1'b1;
        pending_q.push_back(it);
    endtask

    task automatic push_cmd(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                            logic [2:0] c);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_CMD0, c0);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_CMD1, c1);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_CMD2, c2);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_CONTROL, {29'($urandom), c | CT_START});
    endtask

    function automatic logic [31:0] rand_c0();
        logic [7:0]  ops[8];
        logic [31:0] c;
        ops = '{dir_pkg::OP_READ_DISC, dir_pkg::OP_AUDIO_ST, dir_pkg::OP_REQ_ERR,
                dir_pkg::OP_STREAM, dir_pkg::OP_STREAM_ST, dir_pkg::OP_STOP_MOTOR,
                dir_pkg::OP_AUDIO_CFG, 8'h12};
        c = $urandom;
        c[31:24] = ops[$urandom_range(0, 7)];
        if ($urandom_range(0, 7) == 0) c[31:24] = 8'($urandom);
        if ($urandom_range(0, 3) != 0) c[23:18] = '0;
        if ($urandom_range(0, 3) != 0) c[17:16] = 2'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic gen_random(int n);
        int k;
        logic [31:0] c1, c2;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                c1 = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
                c2 = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
                if ($urandom_range(0, 2) == 0)
                begin
                    push(dir_pkg::ACT_WRITE, dir_pkg::OFF_DMAADR, $urandom);
                    push(dir_pkg::ACT_WRITE, dir_pkg::OFF_DMALEN,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8192));
                end
                push_cmd(rand_c0(), c1, c2, 3'($urandom));
                if ($urandom_range(0, 4) != 0) push_done(1'($urandom));
                i += 4;
            end
            else if (k < 65)
                push(dir_pkg::ACT_READ, 8'($urandom_range(0, 9) * 4), $urandom);
            else if (k < 75)
                push(dir_pkg::ACT_WRITE,
                     $urandom_range(0, 1) ? dir_pkg::OFF_STATUS : dir_pkg::OFF_COVER,
                     $urandom);
            else if (k < 82)
                push(dir_pkg::ACT_WRITE, 8'($urandom_range(2, 8) * 4), $urandom);
            else if (k < 88)
                push(dir_pkg::ACT_DISC, 8'($urandom), $urandom);
            else if (k < 90)
                push(dir_pkg::ACT_RESET, 8'($urandom), $urandom);
            else if (k < 95)
                push(dir_pkg::ACT_DONE, 8'($urandom), $urandom);
            else
                push(3'($urandom), 8'($urandom), $urandom);
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        attached = v;
        cfg_valid <= 1'b0;
    endtask

    // ---------------- input driver ----------------
    always @(posedge clk)
    begin
        bus_item_t nxt;
        logic busy;
        if (rst_n)
        begin
            busy = in_valid && !in_ready;
            if (in_valid && in_ready) expected_q.push_back(predict_beat(cur));
            if (!busy)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    if (nxt.live_tag) nxt.ctag = tag_c;
                    cur <= nxt;
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) gap_cnt = $urandom_range(1, 12);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            errs++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, e, a);
        end
    endtask

    always @(posedge clk)
    begin
        reg_result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats++;
                if (expected_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result beat: expected none actual %h",
                             $time, got);
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("ack", 32'(e.ack), 32'(got.ack));
                    check_field("read_data", e.rdata, got.rdata);
                    check_field("irq_pending", 32'(e.irq), 32'(got.irq));
                    check_field("media_request", 32'(e.mreq), 32'(got.mreq));
                    check_field("req_cmd_word0", e.w0, got.w0);
                    check_field("req_cmd_word1", e.w1, got.w1);
                    check_field("req_cmd_word2", e.w2, got.w2);
                    check_field("req_dma_address", e.dadr, got.dadr);
                    check_field("req_dma_length", e.dlen, got.dlen);
                    check_field("req_control", 32'(e.ctl), 32'(got.ctl));
                    check_field("req_immediate", e.imm, got.imm);
                    check_field("req_tag", 32'(e.tag), 32'(got.tag));
                end
            end
            // one long hold to back the block up, plus random stalls while not quiet
            if (beats == HOLD_BEAT && !held)
            begin
                held = 1'b1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 12);
            end
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        attached = 1'b1;
        req = 1'b0;
        drive_reset(1'b1);
        tag_c = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        for (int r = 0; r < 10; r++) push(dir_pkg::ACT_READ, 8'(r * 4), '0);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_CONFIG, 32'hFFFF_FFFF);
        push(dir_pkg::ACT_READ, 8'h02, '0);
        push(dir_pkg::ACT_WRITE, 8'hFF, 32'hFFFF_FFFF);
        push(3'd7, dir_pkg::OFF_STATUS, '0);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_STATUS, 32'hFFFF_FFFF);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_DMAADR, 32'hFFFF_FFFF);
        push(dir_pkg::ACT_WRITE, dir_pkg::OFF_DMALEN, 32'hFFFF_FFFF);
        push_cmd({dir_pkg::OP_READ_DISC, 24'h0}, 32'hFFFF_FFFF, '0, CT_DMA);
        push_done(1'b1);
        push_done(1'b1);
        pending_q.push_back(mk(dir_pkg::ACT_DISC, '0, '0));
        pending_q[$].disc = 1'b0;
        pending_q.push_back(pending_q[$]);
        push_cmd({dir_pkg::OP_READ_DISC, 24'h0}, '0, '0, '0);
        push_cmd({dir_pkg::OP_REQ_ERR, 24'h0}, '0, '0, '0);
        pending_q.push_back(mk(dir_pkg::ACT_RESET, '0, '0));
        pending_q[$].disc = 1'b1;
        gen_random(230);
        drain();

        cfg_write(1'b0);
        gen_random(230);
        drain();

        cfg_write(1'b1);
        quiet = 1'b1;
        gen_random(230);
        drain();

        if (errs == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
